// File: hdl/lvab_pkg.sv
package lvab_pkg;

  // Default sizes
  localparam int DefMaxLabels = 256;
  localparam int DefMaxCols   = 512;
  localparam int DefMaxRows   = 512;

  // Fixed port widths
  localparam int LABEL_W = 9;
  localparam int MODE_W  = 2;
  localparam int WIDX_W  = 2;
  localparam int WORD_W  = 64;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;

  // Marks per voxel: temporal, left pair, top pair
  localparam int NMARK = 5;

  typedef enum logic [1:0] {
    MODE_VOXEL = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_COLS     = 2'd0,
    REG_ROWS     = 2'd1,
    REG_TEMPORAL = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_FRD_T,
    S_FRD_L,
    S_FRD_U,
    S_FWR,
    S_MK_RD,
    S_MK_WR,
    S_Q_RD,
    S_Q_DAT,
    S_DONE
  } state_t;

endpackage

// File: hdl/lvab_ram.sv
module lvab_ram #(
  parameter int W  = 64,
  parameter int D  = 1024,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [W-1:0]  wdata,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: hdl/label_volume_adjacency_builder_top.sv
// Sequence: a voxel makes 4 frame-store accesses (three reads, one write), then a
//   read-modify-write for each of up to 5 armed marks; a query reads one adjacency
//   word; range errors and unused mode go straight to the result; output stalls hold it.
// Throughput: one transaction at a time; input stalls until the sequencer is idle again.
// Reset: synchronous active-low; after reset and on every clear transaction the
//   adjacency RAM is swept to zero, one word a cycle (1024 words by default).
module label_volume_adjacency_builder_top #(
  parameter int MAX_LABELS = lvab_pkg::DefMaxLabels,
  parameter int MAX_COLS   = lvab_pkg::DefMaxCols,
  parameter int MAX_ROWS   = lvab_pkg::DefMaxRows
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lvab_pkg::MODE_W-1:0]   in_mode,
  input  logic [lvab_pkg::LABEL_W-1:0]  in_label,
  input  logic [lvab_pkg::WIDX_W-1:0]   in_word_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lvab_pkg::WORD_W-1:0]   out_neighbor_bits,
  output logic                          out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lvab_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [lvab_pkg::CFG_W-1:0]    cfg_data
);
  import lvab_pkg::*;

  localparam int WPL   = (MAX_LABELS + 63) / 64;
  localparam int ADJ_D = MAX_LABELS * WPL;
  localparam int AW    = (ADJ_D > 1) ? $clog2(ADJ_D) : 1;
  localparam int SD    = MAX_COLS * MAX_ROWS;
  localparam int SAW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);

  function automatic logic lab_ok(input logic [LABEL_W-1:0] x);
    return (x != '0) && (32'(x) <= MAX_LABELS);
  endfunction

  // Registers
  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     cols_cfg_r, cols_cfg_nxt;
  logic [CFG_W-1:0]     rows_cfg_r, rows_cfg_nxt;
  logic                 temp_r, temp_nxt;
  logic [CW-1:0]        col_r, col_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic                 later_r, later_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic                 clr_item_r, clr_item_nxt;
  logic [LABEL_W-1:0]   lab_r, lab_nxt;
  logic [WIDX_W-1:0]    widx_r, widx_nxt;
  logic [SAW-1:0]       pos_r, pos_nxt;
  logic                 has_t_r, has_t_nxt;
  logic                 has_l_r, has_l_nxt;
  logic                 has_u_r, has_u_nxt;
  logic [LABEL_W-1:0]   nb_t_r, nb_t_nxt;
  logic [LABEL_W-1:0]   nb_l_r, nb_l_nxt;
  logic [LABEL_W-1:0]   nb_u_r, nb_u_nxt;
  logic [NMARK-1:0]     mk_en_r, mk_en_nxt;
  logic [2:0]           mk_idx_r, mk_idx_nxt;
  logic [WORD_W-1:0]    res_r, res_nxt;
  logic                 res_st_r, res_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]    out_bits_r, out_bits_nxt;
  logic                 out_st_r, out_st_nxt;

  // Memory ports
  logic                 fs_en, fs_we;
  logic [SAW-1:0]       fs_addr;
  logic [LABEL_W-1:0]   fs_rdata;
  logic                 adj_en, adj_we;
  logic [AW-1:0]        adj_addr;
  logic [WORD_W-1:0]    adj_wdata, adj_rdata;

  // Mark selection
  logic [LABEL_W-1:0]   mk_own, mk_nb, mk_own_m1, mk_nb_m1;
  logic                 mk_on;
  logic [AW-1:0]        mk_addr;
  logic [AW-1:0]        q_addr;
  logic [CW-1:0]        cols_use;
  logic [RW-1:0]        rows_use;
  logic                 accept;

  lvab_ram #(.W(LABEL_W), .D(SD), .AW(SAW)) u_fstore (
    .clk   (clk),
    .en    (fs_en),
    .we    (fs_we),
    .addr  (fs_addr),
    .wdata (lab_r),
    .rdata (fs_rdata)
  );

  lvab_ram #(.W(WORD_W), .D(ADJ_D), .AW(AW)) u_adj (
    .clk   (clk),
    .en    (adj_en),
    .we    (adj_we),
    .addr  (adj_addr),
    .wdata (adj_wdata),
    .rdata (adj_rdata)
  );

  assign in_stall          = (state_r != S_IDLE);
  assign accept            = in_valid && !in_stall;
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_neighbor_bits = out_bits_r;
  assign out_status        = out_st_r;

  // Clamp frame dimensions
  always_comb begin
    if (cols_cfg_r == '0) begin
      cols_use = CW'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_use = CW'(MAX_COLS);
    end else begin
      cols_use = CW'(cols_cfg_r);
    end
    if (rows_cfg_r == '0) begin
      rows_use = RW'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_use = RW'(MAX_ROWS);
    end else begin
      rows_use = RW'(rows_cfg_r);
    end
  end

  // Pick owner and neighbor of the current mark
  always_comb begin
    mk_own = lab_r;
    mk_nb  = lab_r;
    mk_on  = 1'b0;
    case (mk_idx_r)
      3'd0: begin mk_own = nb_t_r; mk_nb = lab_r;  mk_on = mk_en_r[0]; end
      3'd1: begin mk_own = lab_r;  mk_nb = nb_l_r; mk_on = mk_en_r[1]; end
      3'd2: begin mk_own = nb_l_r; mk_nb = lab_r;  mk_on = mk_en_r[2]; end
      3'd3: begin mk_own = lab_r;  mk_nb = nb_u_r; mk_on = mk_en_r[3]; end
      3'd4: begin mk_own = nb_u_r; mk_nb = lab_r;  mk_on = mk_en_r[4]; end
      default: begin mk_on = 1'b0; end
    endcase
    mk_own_m1 = mk_own - LABEL_W'(1);
    mk_nb_m1  = mk_nb - LABEL_W'(1);
    mk_addr   = AW'(32'(mk_own_m1) * WPL + 32'(mk_nb_m1 >> 6));
    q_addr    = AW'(32'(lab_r - LABEL_W'(1)) * WPL + 32'(widx_r));
  end

  // Sequencer: next state, datapath updates, memory controls
  always_comb begin
    state_nxt     = state_r;
    cols_cfg_nxt  = cols_cfg_r;
    rows_cfg_nxt  = rows_cfg_r;
    temp_nxt      = temp_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    later_nxt     = later_r;
    clr_nxt       = clr_r;
    clr_item_nxt  = clr_item_r;
    lab_nxt       = lab_r;
    widx_nxt      = widx_r;
    pos_nxt       = pos_r;
    has_t_nxt     = has_t_r;
    has_l_nxt     = has_l_r;
    has_u_nxt     = has_u_r;
    nb_t_nxt      = nb_t_r;
    nb_l_nxt      = nb_l_r;
    nb_u_nxt      = nb_u_r;
    mk_en_nxt     = mk_en_r;
    mk_idx_nxt    = mk_idx_r;
    res_nxt       = res_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_bits_nxt  = out_bits_r;
    out_st_nxt    = out_st_r;
    fs_en         = 1'b0;
    fs_we         = 1'b0;
    fs_addr       = pos_r;
    adj_en        = 1'b0;
    adj_we        = 1'b0;
    adj_addr      = mk_addr;
    adj_wdata     = adj_rdata | (WORD_W'(1) << mk_nb_m1[5:0]);

    // Configuration writes
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_COLS:     cols_cfg_nxt = cfg_data;
        REG_ROWS:     rows_cfg_nxt = cfg_data;
        REG_TEMPORAL: temp_nxt     = cfg_data[0];
        default: ;
      endcase
    end

    // Drop the output once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        adj_en    = 1'b1;
        adj_we    = 1'b1;
        adj_addr  = clr_r;
        adj_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (32'(clr_r) == ADJ_D - 1) begin
          clr_nxt   = '0;
          state_nxt = clr_item_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          lab_nxt    = in_label;
          widx_nxt   = in_word_index;
          pos_nxt    = SAW'(32'(row_r) * MAX_COLS + 32'(col_r));
          has_t_nxt  = later_r && temp_r;
          has_l_nxt  = (col_r != '0);
          has_u_nxt  = (row_r != '0);
          res_nxt    = '0;
          res_st_nxt = 1'b0;
          state_nxt  = S_DONE;
          unique case (mode_t'(in_mode))
            MODE_VOXEL: begin
              if (lab_ok(in_label)) begin
                state_nxt = S_FRD_T;
              end else begin
                res_st_nxt = 1'b1;
              end
            end
            MODE_QUERY: begin
              if (!lab_ok(in_label)) begin
                res_st_nxt = 1'b1;
              end else if (32'(in_word_index) < WPL) begin
                state_nxt = S_Q_RD;
              end
            end
            MODE_CLEAR: begin
              col_nxt      = '0;
              row_nxt      = '0;
              later_nxt    = 1'b0;
              clr_nxt      = '0;
              clr_item_nxt = 1'b1;
              state_nxt    = S_CLR;
            end
            default: ;
          endcase
        end
      end
      // Read same position, left and top from the frame store
      S_FRD_T: begin
        fs_en     = 1'b1;
        state_nxt = S_FRD_L;
      end
      S_FRD_L: begin
        fs_en     = 1'b1;
        fs_addr   = pos_r - SAW'(1);
        nb_t_nxt  = fs_rdata;
        state_nxt = S_FRD_U;
      end
      S_FRD_U: begin
        fs_en     = 1'b1;
        fs_addr   = pos_r - SAW'(MAX_COLS);
        nb_l_nxt  = fs_rdata;
        state_nxt = S_FWR;
      end
      // Store the label, arm the marks, advance the position
      S_FWR: begin
        fs_en      = 1'b1;
        fs_we      = 1'b1;
        nb_u_nxt   = fs_rdata;
        mk_en_nxt[0] = has_t_r && lab_ok(nb_t_r);
        mk_en_nxt[1] = has_l_r && (nb_l_r != lab_r) && lab_ok(nb_l_r);
        mk_en_nxt[2] = mk_en_nxt[1];
        mk_en_nxt[3] = has_u_r && (fs_rdata != lab_r) && lab_ok(fs_rdata);
        mk_en_nxt[4] = mk_en_nxt[3];
        mk_idx_nxt = '0;
        if (32'(col_r) + 1 >= 32'(cols_use)) begin
          col_nxt = '0;
          if (32'(row_r) + 1 >= 32'(rows_use)) begin
            row_nxt   = '0;
            later_nxt = 1'b1;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          col_nxt = col_r + CW'(1);
        end
        state_nxt = S_MK_RD;
      end
      // Read-modify-write of one adjacency word per armed mark
      S_MK_RD: begin
        if (32'(mk_idx_r) >= NMARK) begin
          state_nxt = S_DONE;
        end else if (mk_on) begin
          adj_en    = 1'b1;
          state_nxt = S_MK_WR;
        end else begin
          mk_idx_nxt = mk_idx_r + 3'd1;
        end
      end
      S_MK_WR: begin
        adj_en     = 1'b1;
        adj_we     = 1'b1;
        mk_idx_nxt = mk_idx_r + 3'd1;
        state_nxt  = S_MK_RD;
      end
      S_Q_RD: begin
        adj_en    = 1'b1;
        adj_addr  = q_addr;
        state_nxt = S_Q_DAT;
      end
      S_Q_DAT: begin
        res_nxt   = adj_rdata;
        state_nxt = S_DONE;
      end
      // Hand the result to the output register
      S_DONE: begin
        clr_item_nxt = 1'b0;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_bits_nxt  = res_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cols_cfg_r  <= CFG_W'(512);
      rows_cfg_r  <= CFG_W'(512);
      temp_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      later_r     <= 1'b0;
      clr_r       <= '0;
      clr_item_r  <= 1'b0;
      mk_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cols_cfg_r  <= cols_cfg_nxt;
      rows_cfg_r  <= rows_cfg_nxt;
      temp_r      <= temp_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      later_r     <= later_nxt;
      clr_r       <= clr_nxt;
      clr_item_r  <= clr_item_nxt;
      mk_idx_r    <= mk_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lab_r      <= lab_nxt;
    widx_r     <= widx_nxt;
    pos_r      <= pos_nxt;
    has_t_r    <= has_t_nxt;
    has_l_r    <= has_l_nxt;
    has_u_r    <= has_u_nxt;
    nb_t_r     <= nb_t_nxt;
    nb_l_r     <= nb_l_nxt;
    nb_u_r     <= nb_u_nxt;
    mk_en_r    <= mk_en_nxt;
    res_r      <= res_nxt;
    res_st_r   <= res_st_nxt;
    out_bits_r <= out_bits_nxt;
    out_st_r   <= out_st_nxt;
  end

  // Assertions
  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MK_WR) |-> ($past(state_r) == S_MK_RD))
    else $error("adjacency write without preceding read");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("accepted transaction left sequencer idle");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (in_stall && !fs_en))
    else $error("input taken during clearing sweep");

  a_clear_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_CLEAR)) |=> ((col_r == '0) && (row_r == '0) && !later_r))
    else $error("clear transaction did not reset position");

endmodule
